>>> hdl/tssr_pkg.sv
// ----------------------------------------------------------------------------
// tssr_pkg: shared types and constants for the three-stop shortest route block
// Field widths, opcodes and the front-to-back command record.
// ----------------------------------------------------------------------------
package tssr_pkg;

    localparam int NODE_W      = 8;
    localparam int CNT_W       = 9;
    localparam int WEIGHT_W    = 16;
    localparam int RESULT_W    = 40;
    localparam int DEF_MAX_NODES   = 256;
    localparam int DEF_MAX_EDGES   = 1024;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [WEIGHT_W-1:0] edge_weight;
        logic [NODE_W-1:0] stop0;
        logic [NODE_W-1:0] stop1;
        logic [NODE_W-1:0] stop2;
        logic              stops_ok;
    } cmd_t;

endpackage

>>> hdl/three_stop_shortest_route.sv
// A solve initialises the layers, then per round reads each edge, relaxes an edge inside
// the graph for all three stops and copies the next layer back, then scores six orders.
// The rate is set by the single-port distance layer memories.
// Loads enter one per cycle through a two-entry queue while the back end is free.
// Reset (synchronous, aresetn low) empties the queue and the edge store, node_count=256.
// ----------------------------------------------------------------------------
// three_stop_shortest_route: least-cost tour through three required nodes
// Edge loading, layered Bellman-Ford relaxation and tour selection.
// ----------------------------------------------------------------------------
module three_stop_shortest_route #(
    parameter int MAX_NODES   = tssr_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES   = tssr_pkg::DEF_MAX_EDGES,
    parameter int WEIGHT_BITS = tssr_pkg::DEF_WEIGHT_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [8:0]          cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    input  logic [7:0]          s_from_node,
    input  logic [7:0]          s_to_node,
    input  logic signed [15:0]  s_edge_weight,
    input  logic [7:0]          s_first_stop,
    input  logic [7:0]          s_second_stop,
    input  logic [7:0]          s_third_stop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_reachable,
    output logic signed [39:0]  m_best_length
);
    import tssr_pkg::*;

    logic [8:0] node_count_reg;
    logic [8:0] eff_nodes;
    cmd_t       q_cmd;
    logic       q_valid, q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) node_count_reg <= 9'd256;
        else if (cfg_valid) node_count_reg <= cfg_data;
    end

    always_comb begin
        if (node_count_reg == 9'd0) eff_nodes = 9'd1;
        else if (32'(node_count_reg) > MAX_NODES) eff_nodes = 9'(MAX_NODES);
        else eff_nodes = node_count_reg;
    end

    tssr_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode, .s_from_node, .s_to_node,
        .s_edge_weight, .s_first_stop, .s_second_stop, .s_third_stop,
        .eff_nodes, .q_cmd, .q_valid, .q_pop
    );

    tssr_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES),
                .WEIGHT_BITS(WEIGHT_BITS)) u_back (
        .aclk, .aresetn, .q_cmd, .q_valid, .q_pop, .eff_nodes,
        .m_valid, .m_ready, .m_reachable, .m_best_length
    );

endmodule

>>> hdl/tssr_front.sv
// ----------------------------------------------------------------------------
// tssr_front: input acceptance and classification
// Takes items, applies the node-count bound checks and fills a two-entry queue.
// ----------------------------------------------------------------------------
module tssr_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [7:0]           s_from_node,
    input  logic [7:0]           s_to_node,
    input  logic signed [15:0]   s_edge_weight,
    input  logic [7:0]           s_first_stop,
    input  logic [7:0]           s_second_stop,
    input  logic [7:0]           s_third_stop,
    input  logic [8:0]           eff_nodes,
    output tssr_pkg::cmd_t       q_cmd,
    output logic                 q_valid,
    input  logic                 q_pop
);
    import tssr_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       in_cmd;
    logic       push;

    always_comb begin
        in_cmd.opcode      = s_opcode;
        in_cmd.from_node   = s_from_node;
        in_cmd.to_node     = s_to_node;
        in_cmd.edge_weight = s_edge_weight;
        in_cmd.stop0       = s_first_stop;
        in_cmd.stop1       = s_second_stop;
        in_cmd.stop2       = s_third_stop;
        in_cmd.stops_ok    = ({1'b0, s_first_stop} < eff_nodes) &&
                             ({1'b0, s_second_stop} < eff_nodes) &&
                             ({1'b0, s_third_stop} < eff_nodes);
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

>>> hdl/tssr_back.sv
// ----------------------------------------------------------------------------
// tssr_back: edge store and layered relaxation engine
// Stores edges, runs the rounds one edge at a time and picks the best tour.
// ----------------------------------------------------------------------------
module tssr_back #(
    parameter int MAX_NODES   = tssr_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES   = tssr_pkg::DEF_MAX_EDGES,
    parameter int WEIGHT_BITS = tssr_pkg::DEF_WEIGHT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tssr_pkg::cmd_t        q_cmd,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  logic [8:0]            eff_nodes,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_reachable,
    output logic signed [39:0]    m_best_length
);
    import tssr_pkg::*;

    // a distance sums at most 255 weights, so it needs WEIGHT_BITS+8 signed bits
    localparam int DIST_W = (WEIGHT_BITS + 10 > 40) ? WEIGHT_BITS + 10 : 40;
    localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W = $clog2(MAX_EDGES + 1);
    localparam int NA_W = $clog2(MAX_NODES);
    localparam int DA_W = NA_W + 2;
    localparam int DEPTH = 1 << DA_W;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_EREAD, S_RD, S_CALC, S_WR, S_COPY, S_COPYW,
        S_PICK, S_PICKW, S_DONE
    } state_t;

    // edge store
    logic [7:0]               est_mem [MAX_EDGES];
    logic [7:0]               een_mem [MAX_EDGES];
    logic [WEIGHT_BITS-1:0]   ecs_mem [MAX_EDGES];
    logic [EC_W-1:0]          edges_loaded_reg;

    // distance layers: bank 0 = prev, bank 1 = next; address {stop, node}
    // entry: valid flag + DIST_W value
    logic [DIST_W:0] prev_mem [DEPTH];
    logic [DIST_W:0] next_mem [DEPTH];
    logic [DIST_W:0] prev_rd_reg, next_rd_reg;

    state_t             state_reg;
    logic [EC_W-1:0]    e_reg;
    logic [8:0]         k_reg;
    logic [1:0]         s_reg;
    logic [NA_W:0]      v_reg;
    logic [7:0]         u_reg, t_reg;
    logic signed [DIST_W-1:0] w_reg;
    logic               skip_reg;
    logic [2:0]         ord_reg;
    logic [1:0]         ph_reg;
    logic [DIST_W:0]    a_reg;
    logic               best_ok_reg;
    logic signed [DIST_W+1:0] best_reg;
    logic [7:0]         st_reg [3];
    logic               rdy_reg, reach_reg;
    logic signed [39:0] len_reg;

    logic [DA_W-1:0]    prev_addr, next_addr;
    logic               prev_we, next_we;
    logic [DIST_W:0]    prev_wd, next_wd;
    logic signed [DIST_W:0] cand;
    logic [1:0]         ps, pt_sel;
    logic [7:0]         pnode;
    logic signed [DIST_W+1:0] tot;

    assign q_pop = q_valid && ((state_reg == S_IDLE && q_cmd.opcode == OP_LOAD) ||
                               (state_reg == S_DONE && !rdy_reg));
    assign m_valid = rdy_reg;
    assign m_reachable = reach_reg;
    assign m_best_length = len_reg;

    function automatic logic [DA_W-1:0] dadr(input logic [1:0] s, input logic [NA_W-1:0] n);
        dadr = {s, n};
    endfunction

    // order table: first leg from stop a to b, second from b to c
    always_comb begin
        case (ord_reg)
            3'd0:    begin ps = (ph_reg == 0) ? 2'd0 : 2'd1; pt_sel = (ph_reg == 0) ? 2'd1 : 2'd2; end
            3'd1:    begin ps = (ph_reg == 0) ? 2'd0 : 2'd2; pt_sel = (ph_reg == 0) ? 2'd2 : 2'd1; end
            3'd2:    begin ps = (ph_reg == 0) ? 2'd1 : 2'd0; pt_sel = (ph_reg == 0) ? 2'd0 : 2'd2; end
            3'd3:    begin ps = (ph_reg == 0) ? 2'd1 : 2'd2; pt_sel = (ph_reg == 0) ? 2'd2 : 2'd0; end
            3'd4:    begin ps = (ph_reg == 0) ? 2'd2 : 2'd0; pt_sel = (ph_reg == 0) ? 2'd0 : 2'd1; end
            default: begin ps = (ph_reg == 0) ? 2'd2 : 2'd1; pt_sel = (ph_reg == 0) ? 2'd1 : 2'd0; end
        endcase
        pnode = st_reg[pt_sel];
    end

    always_comb begin
        cand = $signed(prev_rd_reg[DIST_W-1:0]) + w_reg;
        tot  = $signed(a_reg[DIST_W-1:0]) + $signed(prev_rd_reg[DIST_W-1:0]);
        prev_addr = '0; next_addr = '0;
        prev_we = 1'b0; next_we = 1'b0;
        prev_wd = '0; next_wd = '0;
        case (state_reg)
            S_INIT: begin
                prev_addr = dadr(s_reg, v_reg[NA_W-1:0]);
                prev_we = 1'b1;
                prev_wd = {(v_reg[NA_W-1:0] == NA_W'(st_reg[s_reg])), {DIST_W{1'b0}}};
                next_addr = prev_addr; next_we = 1'b1; next_wd = prev_wd;
            end
            // hold the addresses so the read data is still there in S_WR
            S_RD, S_CALC: begin
                prev_addr = dadr(s_reg, NA_W'(u_reg));
                next_addr = dadr(s_reg, NA_W'(t_reg));
            end
            S_WR: begin
                next_addr = dadr(s_reg, NA_W'(t_reg));
                next_we = prev_rd_reg[DIST_W] &&
                          (!next_rd_reg[DIST_W] ||
                           cand < $signed({next_rd_reg[DIST_W-1], next_rd_reg[DIST_W-1:0]}));
                next_wd = {1'b1, cand[DIST_W-1:0]};
            end
            S_COPY: next_addr = dadr(s_reg, v_reg[NA_W-1:0]);
            S_COPYW: begin
                prev_addr = dadr(s_reg, v_reg[NA_W-1:0]);
                prev_we = 1'b1; prev_wd = next_rd_reg;
            end
            S_PICK: prev_addr = dadr(ps, NA_W'(pnode));
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (prev_we) prev_mem[prev_addr] <= prev_wd;
        prev_rd_reg <= prev_mem[prev_addr];
        if (next_we) next_mem[next_addr] <= next_wd;
        next_rd_reg <= next_mem[next_addr];
        if (state_reg == S_EREAD) begin
            u_reg <= est_mem[e_reg[EA_W-1:0]];
            t_reg <= een_mem[e_reg[EA_W-1:0]];
            w_reg <= DIST_W'($signed(ecs_mem[e_reg[EA_W-1:0]]));
        end
        if (q_pop && q_cmd.opcode == OP_LOAD && edges_loaded_reg < EC_W'(MAX_EDGES)) begin
            est_mem[edges_loaded_reg[EA_W-1:0]] <= q_cmd.from_node;
            een_mem[edges_loaded_reg[EA_W-1:0]] <= q_cmd.to_node;
            ecs_mem[edges_loaded_reg[EA_W-1:0]] <= WEIGHT_BITS'($signed(q_cmd.edge_weight));
        end
        if (!aresetn) begin
            state_reg <= S_IDLE;
            edges_loaded_reg <= '0;
            rdy_reg <= 1'b0;
        end else begin
            if (rdy_reg && m_ready) rdy_reg <= 1'b0;
            if (q_pop && q_cmd.opcode == OP_LOAD && edges_loaded_reg < EC_W'(MAX_EDGES))
                edges_loaded_reg <= edges_loaded_reg + 1'b1;
            case (state_reg)
                S_IDLE: if (q_valid && q_cmd.opcode == OP_SOLVE) begin
                    st_reg[0] <= q_cmd.stop0; st_reg[1] <= q_cmd.stop1;
                    st_reg[2] <= q_cmd.stop2;
                    s_reg <= 2'd0; v_reg <= '0; k_reg <= 9'd1;
                    best_ok_reg <= 1'b0; best_reg <= '0;
                    state_reg <= q_cmd.stops_ok ? S_INIT : S_PICKW;
                    ord_reg <= 3'd6;
                end
                S_INIT: begin
                    if (v_reg == (NA_W+1)'(MAX_NODES - 1)) begin
                        v_reg <= '0;
                        if (s_reg == 2'd2) begin
                            s_reg <= 2'd0; e_reg <= '0;
                            state_reg <= (k_reg < eff_nodes) ? S_EREAD : S_PICK;
                            ord_reg <= 3'd0; ph_reg <= 2'd0;
                        end else s_reg <= s_reg + 1'b1;
                    end else v_reg <= v_reg + 1'b1;
                end
                S_EREAD: begin
                    if (e_reg == edges_loaded_reg) begin
                        state_reg <= S_COPY; v_reg <= '0;
                    end else state_reg <= S_RD;
                    s_reg <= 2'd0;
                end
                S_RD: begin
                    skip_reg <= ({1'b0, u_reg} >= eff_nodes) || ({1'b0, t_reg} >= eff_nodes);
                    state_reg <= S_CALC;
                end
                // drop an edge outside the graph and advance to the next one
                S_CALC: if (skip_reg) begin
                    e_reg <= e_reg + 1'b1; state_reg <= S_EREAD;
                end else state_reg <= S_WR;
                S_WR: begin
                    if (skip_reg || s_reg == 2'd2) begin
                        e_reg <= e_reg + 1'b1; state_reg <= S_EREAD;
                    end else begin
                        s_reg <= s_reg + 1'b1; state_reg <= S_RD;
                    end
                end
                S_COPY: state_reg <= S_COPYW;
                S_COPYW: begin
                    state_reg <= S_COPY;
                    if (v_reg == (NA_W+1)'(MAX_NODES - 1)) begin
                        v_reg <= '0;
                        if (s_reg == 2'd2) begin
                            s_reg <= 2'd0; e_reg <= '0; k_reg <= k_reg + 1'b1;
                            state_reg <= (k_reg + 1'b1 < eff_nodes) ? S_EREAD : S_PICK;
                        end else s_reg <= s_reg + 1'b1;
                    end else v_reg <= v_reg + 1'b1;
                end
                S_PICK: state_reg <= S_PICKW;
                S_PICKW: begin
                    if (ord_reg == 3'd6) begin
                        state_reg <= S_DONE;
                    end else if (ph_reg == 2'd0) begin
                        a_reg <= prev_rd_reg; ph_reg <= 2'd1; state_reg <= S_PICK;
                    end else begin
                        if (a_reg[DIST_W] && prev_rd_reg[DIST_W] &&
                            (!best_ok_reg || tot < best_reg)) begin
                            best_ok_reg <= 1'b1; best_reg <= tot;
                        end
                        ph_reg <= 2'd0; ord_reg <= ord_reg + 1'b1; state_reg <= S_PICK;
                    end
                end
                S_DONE: if (!rdy_reg) begin
                    rdy_reg <= 1'b1;
                    reach_reg <= best_ok_reg;
                    if (!best_ok_reg) len_reg <= '0;
                    else if (best_reg > (DIST_W+2)'(64'sh7FFFFFFFFF)) len_reg <= 40'sh7FFFFFFFFF;
                    else if (best_reg < -(DIST_W+2)'(64'sh8000000000)) len_reg <= 40'sh8000000000;
                    else len_reg <= best_reg[39:0];
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hdl/tssr_checker.sv
// ----------------------------------------------------------------------------
// tssr_checker: port-level checks for the three-stop shortest route block
// Watches the result channel and reset behavior.
// ----------------------------------------------------------------------------
module tssr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_reachable,
    input logic signed [39:0] m_best_length
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_best_length))
        else $error("result dropped while stalled");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reachable |-> m_best_length == 40'sd0)
        else $error("unreachable result not zero");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind three_stop_shortest_route tssr_checker u_tssr_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_reachable, .m_best_length
);

>>> sim/tb_three_stop_shortest_route.sv
// ----------------------------------------------------------------------------
// tb_three_stop_shortest_route: self-checking bench for the three-stop router
// Loads edges and solves tours under several node counts, predicts every
// route result in the bench and compares it field by field with the block.
// ----------------------------------------------------------------------------
module tb_three_stop_shortest_route;
    timeunit 1ns;
    timeprecision 1ps;

    import tssr_pkg::*;

    localparam int      EDGE_CAP   = 1024;
    localparam int      NODE_CAP   = 256;
    localparam longint  IDLE_LIMIT = 2000000;

    typedef struct {
        logic        op;
        logic [7:0]  src;
        logic [7:0]  dst;
        logic [15:0] wt;
        logic [7:0]  stop_a;
        logic [7:0]  stop_b;
        logic [7:0]  stop_c;
    } route_cmd_t;

    typedef struct {
        logic               reach;
        logic signed [39:0] length;
    } route_res_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [8:0]         cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_opcode = 1'b0;
    logic [7:0]         s_from_node = '0;
    logic [7:0]         s_to_node = '0;
    logic signed [15:0] s_edge_weight = '0;
    logic [7:0]         s_first_stop = '0;
    logic [7:0]         s_second_stop = '0;
    logic [7:0]         s_third_stop = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_reachable;
    logic signed [39:0] m_best_length;

    three_stop_shortest_route dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_from_node(s_from_node), .s_to_node(s_to_node),
        .s_edge_weight(s_edge_weight), .s_first_stop(s_first_stop),
        .s_second_stop(s_second_stop), .s_third_stop(s_third_stop),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_reachable(m_reachable), .m_best_length(m_best_length)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // bench copy of the edge store and the node count register
    logic [7:0]  graph_from [EDGE_CAP];
    logic [7:0]  graph_to   [EDGE_CAP];
    longint      graph_cost [EDGE_CAP];
    int          graph_edges = 0;
    logic [8:0]  node_reg = 9'd256;

    route_cmd_t  cmd_q[$];
    route_res_t  route_q[$];
    bit          quiet = 1'b0;
    int          errors = 0;
    int          items_in = 0;
    int          routes_seen = 0;
    int          unreached_seen = 0;
    int          s_gap = 0;
    int          m_gap = 0;
    longint      idle_cycles = 0;

    longint dv [3][NODE_CAP];
    bit     dk [3][NODE_CAP];
    longint nv [3][NODE_CAP];
    bit     nk [3][NODE_CAP];

    function automatic void take_pair(inout bit bk, inout longint bv,
                                      input int sa, input int na,
                                      input int sb, input int nb);
        longint sum;
        if (dk[sa][na] && dk[sb][nb]) begin
            sum = dv[sa][na] + dv[sb][nb];
            if (!bk || sum < bv) begin
                bk = 1'b1;
                bv = sum;
            end
        end
    endfunction

    function automatic route_res_t best_tour(int a, int b, int c);
        int         n;
        int         st[3];
        int         u, t;
        longint     cand, bv;
        bit         bk;
        route_res_t r;
        n = int'(node_reg);
        if (n == 0) n = 1;
        if (n > NODE_CAP) n = NODE_CAP;
        r.reach = 1'b0;
        r.length = '0;
        if (a >= n || b >= n || c >= n) return r;
        st[0] = a; st[1] = b; st[2] = c;
        for (int s = 0; s < 3; s++) begin
            for (int v = 0; v < NODE_CAP; v++) begin
                dk[s][v] = 1'b0;
                dv[s][v] = 0;
            end
            dk[s][st[s]] = 1'b1;
        end
        for (int k = 1; k < n; k++) begin
            nv = dv;
            nk = dk;
            for (int e = 0; e < graph_edges; e++) begin
                u = int'(graph_from[e]);
                t = int'(graph_to[e]);
                if (u < n && t < n) begin
                    for (int s = 0; s < 3; s++) begin
                        if (dk[s][u]) begin
                            cand = dv[s][u] + graph_cost[e];
                            if (!nk[s][t] || cand < nv[s][t]) begin
                                nk[s][t] = 1'b1;
                                nv[s][t] = cand;
                            end
                        end
                    end
                end
            end
            dv = nv;
            dk = nk;
        end
        bk = 1'b0;
        bv = 0;
        take_pair(bk, bv, 0, st[1], 1, st[2]);
        take_pair(bk, bv, 0, st[2], 2, st[1]);
        take_pair(bk, bv, 1, st[0], 0, st[2]);
        take_pair(bk, bv, 1, st[2], 2, st[0]);
        take_pair(bk, bv, 2, st[0], 0, st[1]);
        take_pair(bk, bv, 2, st[1], 1, st[0]);
        if (!bk) return r;
        if (bv > 64'sd549755813887) bv = 64'sd549755813887;
        if (bv < -64'sd549755813888) bv = -64'sd549755813888;
        r.reach = 1'b1;
        r.length = bv[39:0];
        return r;
    endfunction

    task automatic add_edge(logic [7:0] f, logic [7:0] t, logic [15:0] w);
        route_cmd_t c;
        c.op = OP_LOAD;
        c.src = f; c.dst = t; c.wt = w;
        c.stop_a = 8'($urandom); c.stop_b = 8'($urandom); c.stop_c = 8'($urandom);
        cmd_q = {cmd_q, c};
        if (graph_edges < EDGE_CAP) begin
            graph_from[graph_edges] = f;
            graph_to[graph_edges] = t;
            graph_cost[graph_edges] = longint'($signed(w));
            graph_edges++;
        end
    endtask

    task automatic add_solve(logic [7:0] a, logic [7:0] b, logic [7:0] c3);
        route_cmd_t c;
        c.op = OP_SOLVE;
        c.src = 8'($urandom); c.dst = 8'($urandom); c.wt = 16'($urandom);
        c.stop_a = a; c.stop_b = b; c.stop_c = c3;
        cmd_q = {cmd_q, c};
        route_q = {route_q, best_tour(int'(a), int'(b), int'(c3))};
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (cmd_q.size() != 0 || s_valid || route_q.size() != 0);
        // a trailing load may still be in flight
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_nodes(logic [8:0] v);
        wait_idle();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        node_reg = v;
    endtask

    // input driver
    always @(posedge aclk) begin
        route_cmd_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) items_in++;
            if (s_valid && !s_ready) begin
                // hold the item until accepted
            end else if (s_gap > 0) begin
                s_gap--;
                s_valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                c = cmd_q.pop_front();
                s_opcode <= c.op;
                s_from_node <= c.src;
                s_to_node <= c.dst;
                s_edge_weight <= c.wt;
                s_first_stop <= c.stop_a;
                s_second_stop <= c.stop_b;
                s_third_stop <= c.stop_c;
                s_valid <= 1'b1;
                s_gap = quiet ? 0 : $urandom_range(0, 9);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        route_res_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (route_q.size() == 0) begin
                    $error("route result with none expected");
                    errors++;
                end else begin
                    e = route_q.pop_front();
                    routes_seen++;
                    if (!e.reach) unreached_seen++;
                    if (m_reachable !== e.reach) begin
                        $error("reachable: expected %0d, got %0d", e.reach, m_reachable);
                        errors++;
                    end
                    if (m_best_length !== e.length) begin
                        $error("best_length: expected %0d, got %0d",
                               e.length, m_best_length);
                        errors++;
                    end
                end
                m_gap = quiet ? 0 : $urandom_range(0, 9);
            end
            if (m_gap > 0) begin
                m_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [7:0] pick_node(int n);
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return 8'($urandom_range(0, n - 1));
    endfunction

    function automatic logic [15:0] pick_weight();
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 100)) - 30);
    endfunction

    initial begin
        int n;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset node count: extreme weights, a negative cycle, a self loop
        add_edge(8'd0, 8'd1, 16'h8000);
        add_edge(8'd1, 8'd2, 16'h7FFF);
        add_edge(8'd2, 8'd0, 16'd5);
        add_edge(8'd255, 8'd254, 16'hFFFF);
        add_edge(8'd254, 8'd255, 16'hFFFF);
        add_edge(8'd7, 8'd7, 16'd0);
        add_solve(8'd0, 8'd1, 8'd2);
        // above the node limit: clamp, and no tour links the two groups
        set_nodes(9'd511);
        add_solve(8'd255, 8'd254, 8'd0);
        // zero nodes acts as one
        set_nodes(9'd0);
        add_solve(8'd0, 8'd0, 8'd0);
        add_solve(8'd1, 8'd0, 8'd0);
        set_nodes(9'd1);
        add_solve(8'd0, 8'd0, 8'd0);
        set_nodes(9'd3);
        add_solve(8'd0, 8'd1, 8'd2);
        add_solve(8'd2, 8'd2, 8'd2);
        add_solve(8'd0, 8'd1, 8'd3);
        add_edge(8'd3, 8'd0, 16'd1);
        add_solve(8'd1, 8'd0, 8'd2);
        add_solve(8'd2, 8'd1, 8'd0);

        // random segments, each under its own small node count
        for (int seg = 0; seg < 9; seg++) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 10) : $urandom_range(2, 5);
            set_nodes(9'(n));
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 100; i++) begin
                if ($urandom_range(0, 99) < 7)
                    add_solve(pick_node(n), pick_node(n), pick_node(n));
                else
                    add_edge(pick_node(n), pick_node(n), pick_weight());
            end
        end

        // fill the edge store past capacity, extra loads are dropped
        set_nodes(9'd2);
        quiet = 1'b0;
        add_solve(8'd0, 8'd1, 8'd1);
        while (graph_edges < EDGE_CAP) add_edge(pick_node(2), pick_node(2), pick_weight());
        for (int i = 0; i < 20; i++) add_edge(8'd0, 8'd1, 16'h8000);
        add_solve(8'd0, 8'd1, 8'd0);
        add_solve(8'd1, 8'd1, 8'd1);
        add_solve(8'd0, 8'd0, 8'd1);

        wait_idle();
        repeat (50) @(posedge aclk);
        $display("run covered %0d items, %0d route results (%0d unreachable), %0d edges stored",
                 items_in, routes_seen, unreached_seen, graph_edges);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/tssr_pkg.sv
hdl/tssr_front.sv
hdl/tssr_back.sv
hdl/three_stop_shortest_route.sv
hdl/tssr_checker.sv
sim/tb_three_stop_shortest_route.sv
